/* rtl/core/pmr_pkg.sv */
// Shared types and constants for the payment reference mod-11 checker.
`default_nettype none

package pmr_pkg;

   // Default length limits
   localparam int MAX_TOTAL_LEN_DEF = 22;
   localparam int MAX_PART_LEN_DEF  = 12;

   // Character codes
   localparam logic [7:0] CHAR_DASH = 8'd45;
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_NINE = 8'd57;

   // Check digit modulus
   localparam logic [4:0] MOD_BASE = 5'd11;

   // Verdict codes
   localparam int         STATUS_W       = 4;
   localparam logic [3:0] STATUS_OK      = 4'd0;
   localparam logic [3:0] STATUS_SHORT   = 4'd1;
   localparam logic [3:0] STATUS_LONG    = 4'd2;
   localparam logic [3:0] STATUS_BADCHAR = 4'd3;
   localparam logic [3:0] STATUS_DASHES  = 4'd4;
   localparam logic [3:0] STATUS_P1_LONG = 4'd5;
   localparam logic [3:0] STATUS_P2_LONG = 4'd6;
   localparam logic [3:0] STATUS_P3_LONG = 4'd7;
   localparam logic [3:0] STATUS_P1_SHORT = 4'd8;
   localparam logic [3:0] STATUS_CHECK   = 4'd9;

   // One word moving from the input register into the checking engine
   typedef struct packed {
      logic       fire;
      logic       is_end;
      logic [7:0] ch;
   } pmr_step_type;

endpackage

`default_nettype wire

/* rtl/core/pmr_if.sv */
// Request and response channel interfaces of the payment reference checker.
`default_nettype none

interface pmr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_end;

   modport source (output valid, output ch, output is_end, input ready);
   modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface pmr_rsp_if import pmr_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                valid_res;

   modport source (output valid, output status, output valid_res, input ready);
   modport sink   (input valid, input status, input valid_res, output ready);
endinterface

`default_nettype wire

/* rtl/core/pmr_engine.sv */
// Running string state and verdict logic of the payment reference checker.
`default_nettype none

module pmr_engine import pmr_pkg::*; #(
   parameter int MaxTotalLen = MAX_TOTAL_LEN_DEF,
   parameter int MaxPartLen  = MAX_PART_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pmr_step_type        step,
   output logic [STATUS_W-1:0] status
);

   localparam int LenMax = (MaxPartLen > MaxTotalLen) ? MaxPartLen : MaxTotalLen;
   localparam int LenW   = $clog2(LenMax + 2);
   localparam logic [LenW-1:0] LenSat   = LenW'(MaxTotalLen + 1);
   localparam logic [LenW-1:0] TotalMax = LenW'(MaxTotalLen);
   localparam logic [LenW-1:0] PartMax  = LenW'(MaxPartLen);
   localparam logic [LenW-1:0] MinLen   = LenW'(2);

   logic [LenW-1:0] char_count_ff, char_count_in;
   logic [1:0]      dash_count_ff, dash_count_in;
   logic            bad_char_ff, bad_char_in;
   logic [LenW-1:0] part_len_ff [3];
   logic [LenW-1:0] part_len_in [3];
   logic [3:0]      digit_sum_ff, digit_sum_in;
   logic [3:0]      weighted_sum_ff, weighted_sum_in;
   logic [3:0]      pending_ff, pending_in;

   logic       is_dash;
   logic       is_digit;
   logic [3:0] digit;
   logic [4:0] ds_raw;
   logic [3:0] ds_mod;
   logic [4:0] ws_raw;
   logic [4:0] r_raw;
   logic [3:0] r_mod;
   logic [3:0] expect_digit;

   assign is_dash  = (step.ch == CHAR_DASH);
   assign is_digit = (step.ch >= CHAR_ZERO) && (step.ch <= CHAR_NINE);
   assign digit    = step.ch[3:0];

   // Fold the new digit into the running sums, both kept mod 11
   always_comb begin
      ds_raw = {1'b0, digit_sum_ff} + {1'b0, digit};
      ds_mod = (ds_raw >= MOD_BASE) ? 4'(ds_raw - MOD_BASE) : ds_raw[3:0];
      ws_raw = {1'b0, weighted_sum_ff} + {1'b0, ds_mod};
   end

   // Advance the string state on a character, clear it on an end word
   always_comb begin
      char_count_in   = char_count_ff;
      dash_count_in   = dash_count_ff;
      bad_char_in     = bad_char_ff;
      digit_sum_in    = digit_sum_ff;
      weighted_sum_in = weighted_sum_ff;
      pending_in      = pending_ff;
      for (int i = 0; i < 3; i++) begin
         part_len_in[i] = part_len_ff[i];
      end
      if (step.fire && step.is_end) begin
         char_count_in   = '0;
         dash_count_in   = '0;
         bad_char_in     = 1'b0;
         digit_sum_in    = '0;
         weighted_sum_in = '0;
         pending_in      = '0;
         for (int i = 0; i < 3; i++) begin
            part_len_in[i] = '0;
         end
      end else if (step.fire) begin
         if (char_count_ff < LenSat) begin
            char_count_in = char_count_ff + LenW'(1);
         end
         if (is_dash) begin
            if (dash_count_ff != 2'd3) begin
               dash_count_in = dash_count_ff + 2'd1;
            end
         end else begin
            if (!is_digit) begin
               bad_char_in = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
               if (dash_count_ff == 2'(i) && part_len_ff[i] < LenSat) begin
                  part_len_in[i] = part_len_ff[i] + LenW'(1);
               end
            end
            if (dash_count_ff == 2'd0 && is_digit) begin
               digit_sum_in    = ds_mod;
               weighted_sum_in = (ws_raw >= MOD_BASE) ? 4'(ws_raw - MOD_BASE) : ws_raw[3:0];
               pending_in      = digit;
            end
         end
      end
   end

   // Hold the string state
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff   <= '0;
         dash_count_ff   <= '0;
         bad_char_ff     <= 1'b0;
         digit_sum_ff    <= '0;
         weighted_sum_ff <= '0;
         pending_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            part_len_ff[i] <= '0;
         end
      end else begin
         char_count_ff   <= char_count_in;
         dash_count_ff   <= dash_count_in;
         bad_char_ff     <= bad_char_in;
         digit_sum_ff    <= digit_sum_in;
         weighted_sum_ff <= weighted_sum_in;
         pending_ff      <= pending_in;
         for (int i = 0; i < 3; i++) begin
            part_len_ff[i] <= part_len_in[i];
         end
      end
   end

   // Drop the check digit from the weighted sum and derive the expected digit
   always_comb begin
      r_raw = {1'b0, weighted_sum_ff} + MOD_BASE - {1'b0, pending_ff};
      r_mod = (r_raw >= MOD_BASE) ? 4'(r_raw - MOD_BASE) : r_raw[3:0];
      if (r_mod == 4'd0) begin
         expect_digit = 4'd1;
      end else if (r_mod == 4'd1) begin
         expect_digit = 4'd0;
      end else begin
         expect_digit = 4'(MOD_BASE - {1'b0, r_mod});
      end
   end

   // Pick the highest priority error, or OK when there is none
   always_comb begin
      if (char_count_ff < MinLen) begin
         status = STATUS_SHORT;
      end else if (char_count_ff > TotalMax) begin
         status = STATUS_LONG;
      end else if (bad_char_ff) begin
         status = STATUS_BADCHAR;
      end else if (dash_count_ff == 2'd3) begin
         status = STATUS_DASHES;
      end else if (part_len_ff[0] > PartMax) begin
         status = STATUS_P1_LONG;
      end else if (part_len_ff[1] > PartMax) begin
         status = STATUS_P2_LONG;
      end else if (part_len_ff[2] > PartMax) begin
         status = STATUS_P3_LONG;
      end else if (part_len_ff[0] < MinLen) begin
         status = STATUS_P1_SHORT;
      end else if (expect_digit != pending_ff) begin
         status = STATUS_CHECK;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/payment_reference_mod11_check.sv */
// Top level of the payment reference mod-11 checker.
//
//   channel   direction  word                        handshake
//   req_port  in         ch[7:0], is_end             valid/ready
//   rsp_port  out        status[3:0], valid_res      valid/ready
//
// One word is taken per cycle unless an end word is held in the input register
// by a full response register. Each word passes through the input register,
// then updates the string state; an end word loads its verdict into the
// response register, which offers it on the response channel.
// Synchronous reset clears the input and response valid flags and the state.
// A stalled response blocks only a following end word; characters keep
// flowing past it into the string state.
`default_nettype none

module payment_reference_mod11_check import pmr_pkg::*; #(
   parameter int MaxTotalLen = MAX_TOTAL_LEN_DEF,
   parameter int MaxPartLen  = MAX_PART_LEN_DEF
) (
   input logic         clock,
   input logic         reset,
   pmr_req_if.sink     req_port,
   pmr_rsp_if.source   rsp_port
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_ch_ff;
   logic                in_end_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] verdict;
   logic                out_free;
   logic                advance;
   logic                take;
   pmr_step_type        step;

   // Advance the input word unless it is an end word facing a full response that is not being taken
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign advance  = in_valid_ff && (!in_end_ff || out_free);
   assign req_port.ready = !in_valid_ff || advance;
   assign take     = req_port.valid && req_port.ready;

   assign in_valid_in = take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (take) begin
         in_ch_ff  <= req_port.ch;
         in_end_ff <= req_port.is_end;
      end
   end

   assign step = '{fire: advance, is_end: in_end_ff, ch: in_ch_ff};

   pmr_engine #(
      .MaxTotalLen (MaxTotalLen),
      .MaxPartLen  (MaxPartLen)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .status (verdict)
   );

   // Load the verdict on an end word, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      if (advance && in_end_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_end_ff) begin
         rsp_status_ff <= verdict;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.status    = rsp_status_ff;
   assign rsp_port.valid_res = (rsp_status_ff == STATUS_OK);

endmodule

`default_nettype wire

/* rtl/core/pmr_checker.sv */
// Port-level assertions for the payment reference checker, bound to its top level.
`default_nettype none

module pmr_checker import pmr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_valid_res
);

   // A verdict flag agrees with its status code
   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_valid_res == (rsp_status == STATUS_OK)))
      else $error("valid_res disagrees with status");

   // Status codes stay within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_CHECK))
      else $error("status code out of range");

   // A stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled verdict changed or vanished");

   // No verdict right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict present after reset");

   // After reset the input side is ready
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready after reset");

endmodule

bind payment_reference_mod11_check pmr_checker u_pmr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_port.valid),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_status    (rsp_port.status),
   .rsp_valid_res (rsp_port.valid_res)
);

`default_nettype wire

/* sim/pmr_verdict_checker.sv */
// Checker for the payment reference block: predicts each verdict and compares it.
`default_nettype none

module pmr_verdict_checker import pmr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pmr_req_if          req_mon,
   pmr_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned verdicts_open,
   output int unsigned verdicts_checked,
   output logic [9:0]  codes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [4:0] LEN_SAT = 5'(MAX_TOTAL_LEN_DEF + 1);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                valid_res;
   } verdict_type;

   verdict_type expected_verdicts[$];

   // Running picture of the reference being streamed in
   logic [4:0] char_total;
   logic [1:0] dash_total;
   logic       saw_bad_char;
   logic [4:0] part_len [3];
   logic [3:0] digit_sum;
   logic [3:0] weighted_sum;
   logic [3:0] last_digit;

   task automatic clear_reference();
      char_total   = '0;
      dash_total   = '0;
      saw_bad_char = 1'b0;
      part_len     = '{default: '0};
      digit_sum    = '0;
      weighted_sum = '0;
      last_digit   = '0;
   endtask

   // Fold one character into the counts and the first-part sums
   task automatic absorb_char(input logic [7:0] c);
      logic       is_digit;
      logic [3:0] d;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (char_total < LEN_SAT) char_total++;
      if (c == CHAR_DASH) begin
         if (dash_total < 2'd3) dash_total++;
      end else begin
         if (!is_digit) saw_bad_char = 1'b1;
         if (dash_total < 2'd3) begin
            if (part_len[dash_total] < LEN_SAT) part_len[dash_total]++;
         end
         if (dash_total == 2'd0 && is_digit) begin
            d            = 4'(c - CHAR_ZERO);
            digit_sum    = 4'((int'(digit_sum) + int'(d)) % int'(MOD_BASE));
            weighted_sum = 4'((int'(weighted_sum) + int'(digit_sum)) % int'(MOD_BASE));
            last_digit   = d;
         end
      end
   endtask

   // Work out the status code for the reference seen so far
   function automatic logic [STATUS_W-1:0] judge_reference();
      logic [3:0] rem;
      logic [3:0] want_digit;
      if (char_total < 5'd2) return STATUS_SHORT;
      if (char_total > 5'(MAX_TOTAL_LEN_DEF)) return STATUS_LONG;
      if (saw_bad_char) return STATUS_BADCHAR;
      if (dash_total > 2'd2) return STATUS_DASHES;
      if (part_len[0] > 5'(MAX_PART_LEN_DEF)) return STATUS_P1_LONG;
      if (part_len[1] > 5'(MAX_PART_LEN_DEF)) return STATUS_P2_LONG;
      if (part_len[2] > 5'(MAX_PART_LEN_DEF)) return STATUS_P3_LONG;
      if (part_len[0] < 5'd2) return STATUS_P1_SHORT;
      // drop the candidate digit from the weighted sum, then map 11 to 1 and 10 to 0
      rem = 4'((int'(weighted_sum) + int'(MOD_BASE) - int'(last_digit)) % int'(MOD_BASE));
      if (rem == 4'd0) want_digit = 4'd1;
      else if (rem == 4'd1) want_digit = 4'd0;
      else want_digit = 4'(int'(MOD_BASE) - int'(rem));
      return (want_digit == last_digit) ? STATUS_OK : STATUS_CHECK;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         clear_reference();
         expected_verdicts.delete();
         mismatch_count   = 0;
         verdicts_checked = 0;
         codes_seen       = '0;
      end else begin
         // Advance the prediction on every accepted request word
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.is_end) begin
               want.status    = judge_reference();
               want.valid_res = (want.status == STATUS_OK);
               expected_verdicts.push_back(want);
               codes_seen[want.status] = 1'b1;
               clear_reference();
            end else begin
               absorb_char(req_mon.ch);
            end
         end
         // Compare each accepted response word with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_verdicts.size() == 0) begin
               $display({"%0t ns: unexpected verdict, expected none, ",
                         "got status %0d valid_res %0b"},
                        $time, rsp_mon.status, rsp_mon.valid_res);
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_mon.status !== want.status || rsp_mon.valid_res !== want.valid_res) begin
                  $display({"%0t ns: verdict mismatch, expected status %0d valid_res %0b, ",
                            "got status %0d valid_res %0b"},
                           $time, want.status, want.valid_res, rsp_mon.status,
                           rsp_mon.valid_res);
                  mismatch_count++;
               end
               verdicts_checked++;
            end
         end
      end
      verdicts_open = expected_verdicts.size();
   end

endmodule

`default_nettype wire

/* sim/payment_reference_mod11_check_tb.sv */
// Testbench top: drives references into the mod-11 checker and reports whether the verdicts matched.
`default_nettype none

module payment_reference_mod11_check_tb import pmr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      SHAPE_VALID,
      SHAPE_BAD_CHECK,
      SHAPE_JUNK,
      SHAPE_EXTRA_DASH,
      SHAPE_LONG_PART,
      SHAPE_LONG_TOTAL,
      SHAPE_SHORT_P1,
      SHAPE_TINY,
      SHAPE_NOISE
   } ref_shape_type;

   localparam logic [7:0] BOUNDARY_BYTES [8] =
      '{8'h00, 8'h2F, 8'h3A, 8'h7F, 8'h80, 8'hFF, 8'h2C, 8'h2E};
   localparam int unsigned ACCEPT_PCT [4] = '{100, 60, 25, 5};

   logic clock = 1'b0;
   logic reset;

   pmr_req_if req_bus ();
   pmr_rsp_if rsp_bus ();

   int unsigned mismatch_count;
   int unsigned verdicts_open;
   int unsigned verdicts_checked;
   logic [9:0]  codes_seen;

   logic [7:0]  ref_text[$];
   int unsigned words_sent = 0;
   int unsigned refs_sent  = 0;
   int unsigned burst_left = 0;
   bit          hold_off_req = 1'b0;

   payment_reference_mod11_check u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   pmr_verdict_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .mismatch_count   (mismatch_count),
      .verdicts_open    (verdicts_open),
      .verdicts_checked (verdicts_checked),
      .codes_seen       (codes_seen)
   );

   always #6 clock = ~clock;

   // Pick a byte that is neither a digit nor a dash, often one next to a boundary
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) return BOUNDARY_BYTES[$urandom_range(0, 7)];
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_DASH || (c >= CHAR_ZERO && c <= CHAR_NINE));
      return c;
   endfunction

   task automatic load_text(input string s);
      ref_text.delete();
      for (int i = 0; i < s.len(); i++) ref_text.push_back(s[i]);
   endtask

   // Build digits for each part, closing the first part with its check digit (spoilt when spoil_check is set)
   task automatic compose_reference(input int lens [3], input int n_parts,
                                    input bit spoil_check);
      int wsum;
      int d;
      int rem;
      int chk;
      ref_text.delete();
      wsum = 0;
      for (int i = 0; i + 1 < lens[0]; i++) begin
         d = $urandom_range(0, 9);
         wsum += d * (lens[0] - i);
         ref_text.push_back(CHAR_ZERO + 8'(d));
      end
      if (lens[0] > 0) begin
         rem = wsum % int'(MOD_BASE);
         chk = (rem == 0) ? 1 : (rem == 1) ? 0 : int'(MOD_BASE) - rem;
         if (spoil_check) chk = (chk + int'($urandom_range(1, 9))) % 10;
         ref_text.push_back(CHAR_ZERO + 8'(chk));
      end
      for (int p = 1; p < n_parts; p++) begin
         ref_text.push_back(CHAR_DASH);
         repeat (lens[p]) ref_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
   endtask

   function automatic ref_shape_type pick_shape();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return SHAPE_VALID;
      if (r < 55) return SHAPE_BAD_CHECK;
      if (r < 63) return SHAPE_JUNK;
      if (r < 71) return SHAPE_EXTRA_DASH;
      if (r < 78) return SHAPE_LONG_PART;
      if (r < 84) return SHAPE_LONG_TOTAL;
      if (r < 89) return SHAPE_SHORT_P1;
      if (r < 92) return SHAPE_TINY;
      return SHAPE_NOISE;
   endfunction

   // Fill ref_text with one reference of the given shape
   task automatic shape_reference(input ref_shape_type shape);
      int lens [3];
      int n_parts;
      int room;
      int target;
      int pos;
      n_parts = $urandom_range(1, 3);
      lens[0] = $urandom_range(2, MAX_PART_LEN_DEF);
      room    = MAX_TOTAL_LEN_DEF - lens[0] - (n_parts - 1);
      lens[1] = (n_parts > 1) ?
                $urandom_range(0, (room < MAX_PART_LEN_DEF) ? room : MAX_PART_LEN_DEF) : 0;
      room   -= lens[1];
      lens[2] = (n_parts > 2) ?
                $urandom_range(0, (room < MAX_PART_LEN_DEF) ? room : MAX_PART_LEN_DEF) : 0;
      case (shape)
         SHAPE_LONG_PART: begin
            n_parts = 3;
            lens    = '{$urandom_range(2, 6), $urandom_range(0, 5), $urandom_range(0, 5)};
            lens[$urandom_range(0, 2)] =
               $urandom_range(MAX_PART_LEN_DEF + 1, MAX_PART_LEN_DEF + 3);
         end
         SHAPE_LONG_TOTAL: begin
            n_parts = 3;
            lens[0] = $urandom_range(9, MAX_PART_LEN_DEF);
            lens[1] = $urandom_range(5, MAX_PART_LEN_DEF);
            target  = $urandom_range(MAX_TOTAL_LEN_DEF - 1, MAX_TOTAL_LEN_DEF + 3);
            lens[2] = target - lens[0] - lens[1] - 2;
            if (lens[2] < 0) lens[2] = 0;
         end
         SHAPE_SHORT_P1: begin
            n_parts = $urandom_range(2, 3);
            lens[0] = $urandom_range(0, 1);
         end
         SHAPE_TINY: begin
            n_parts = 1;
            lens[0] = $urandom_range(0, 1);
         end
         default: ;
      endcase
      compose_reference(lens, n_parts, shape == SHAPE_BAD_CHECK);
      case (shape)
         SHAPE_JUNK: begin
            repeat ($urandom_range(1, 2)) begin
               pos = $urandom_range(0, ref_text.size());
               if (pos == ref_text.size()) ref_text.push_back(junk_char());
               else ref_text[pos] = junk_char();
            end
         end
         SHAPE_EXTRA_DASH: begin
            repeat ($urandom_range(1, 3)) begin
               pos = $urandom_range(0, ref_text.size());
               ref_text.insert(pos, CHAR_DASH);
            end
         end
         SHAPE_NOISE: begin
            ref_text.delete();
            repeat ($urandom_range(0, 28)) begin
               pos = $urandom_range(0, 99);
               if (pos < 50) ref_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
               else if (pos < 65) ref_text.push_back(CHAR_DASH);
               else ref_text.push_back(junk_char());
            end
         end
         default: ;
      endcase
   endtask

   // Offer one word, first idling for a random gap (possibly none) when a burst has run out
   task automatic send_word(input logic [7:0] c, input logic last);
      bit          taken;
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ?
                      $urandom_range(20, 60) : $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid  <= 1'b1;
      req_bus.ch     <= c;
      req_bus.is_end <= last;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      words_sent++;
   endtask

   task automatic send_reference();
      foreach (ref_text[i]) send_word(ref_text[i], 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1);
      refs_sent++;
   endtask

   // Drop valid and hold until every predicted verdict has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (verdicts_open != 0);
      @(posedge clock);
   endtask

   // Response side: stall in phases of random length and acceptance rate, or fully when hold_off_req is set
   initial begin : rsp_stall_pattern
      int unsigned span;
      int unsigned pct;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            span         = 300;
            pct          = 0;
         end else begin
            span = $urandom_range(1, 40);
            pct  = ACCEPT_PCT[$urandom_range(0, 3)];
         end
         repeat (span) begin
            rsp_bus.ready <= ($urandom_range(1, 100) <= pct);
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.ch     <= '0;
      req_bus.is_end <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed references: extremes, boundary bytes and five of the error classes
      load_text("");      send_reference();
      load_text("7");     send_reference();
      load_text("19");    send_reference();
      load_text("18");    send_reference();
      ref_text = '{8'h00, CHAR_ZERO + 8'd5};  send_reference();
      ref_text = '{CHAR_ZERO + 8'd5, 8'hFF};  send_reference();
      load_text("1---2"); send_reference();
      load_text("-55");   send_reference();

      // Random references of random shapes, valid ones the most common, with random content
      while (words_sent < 400) begin
         if (refs_sent == 12) hold_off_req = 1'b1;
         if (refs_sent == 20) wait_drained();
         shape_reference(pick_shape());
         send_reference();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      @(negedge clock);
      $display("Streamed %0d words in %0d references; %0d verdicts compared.",
               words_sent, refs_sent, verdicts_checked);
      $display("Distinct status codes predicted: %0d of 10.", $countones(codes_seen));
      if (mismatch_count == 0 && verdicts_open == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #3ms;
      $display("Run timed out with %0d verdicts outstanding", verdicts_open);
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
